// ===== design/maa_pkg.sv =====
// ============================================================================
// maa_pkg
// Shared constants for the moving-average anomaly alarm: field widths,
// default window depths and the threshold reset value.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package maa_pkg;

    // Field widths of the sample, threshold and result words
    localparam int SAMPLE_W    = 16;
    localparam int THRESH_W    = 7;
    localparam int AVG_W       = 16;
    localparam int COUNT_OUT_W = 5;

    // Default ring and sub-window depths
    localparam int WINDOW_DEPTH_DEF    = 100;
    localparam int SUBWINDOW_DEPTH_DEF = 20;

    // Threshold in percent: reset value and full scale
    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd75;
    localparam int                  PERCENT_FULL = 100;

endpackage : maa_pkg

`default_nettype wire

// ===== design/maa_sample_if.sv =====
// ============================================================================
// maa_sample_if
// Valid/ready channel that carries one sensor sample per word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface maa_sample_if;

    logic                          valid;
    logic                          ready;
    logic [maa_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface : maa_sample_if

`default_nettype wire

// ===== design/maa_result_if.sv =====
// ============================================================================
// maa_result_if
// Valid/ready channel that carries one detector result per word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface maa_result_if;

    logic                             valid;
    logic                             ready;
    logic                             alarm;
    logic                             sample_anomalous;
    logic [maa_pkg::AVG_W-1:0]        window_average;
    logic [maa_pkg::COUNT_OUT_W-1:0]  flagged_count;

    modport source (output valid, output alarm, output sample_anomalous,
                    output window_average, output flagged_count, input ready);
    modport sink   (input valid, input alarm, input sample_anomalous,
                    input window_average, input flagged_count, output ready);

endinterface : maa_result_if

`default_nettype wire

// ===== design/maa_const_div.sv =====
// ============================================================================
// maa_const_div
// Registered floor division by a constant: multiply by a rounded-up
// reciprocal and drop the fraction bits. Exact for every IN_W-bit input.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module maa_const_div #(
    parameter int IN_W    = 23,
    parameter int DIVISOR = 100,
    parameter int OUT_W   = 16
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [IN_W-1:0]  dividend,
    output logic      [OUT_W-1:0] quotient_reg
);

    // Shift of IN_W + ceil(log2 D) keeps the error below one part in D
    localparam int SHIFT   = IN_W + $clog2(DIVISOR);
    localparam int RECIP_W = IN_W + 1;
    localparam int PROD_W  = IN_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(dividend) * PROD_W'(RECIP);

    // Quotient register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quotient_reg <= OUT_W'(prod >> SHIFT);
        end
    end

endmodule : maa_const_div

`default_nettype wire

// ===== design/maa_sample_ring.sv =====
// ============================================================================
// maa_sample_ring
// Sample ring memory: one port that writes the new sample and returns the
// old content of the same slot through a read register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module maa_sample_ring #(
    parameter int DEPTH  = 100,
    parameter int ADDR_W = 7
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [ADDR_W-1:0]            addr,
    input  wire logic [maa_pkg::SAMPLE_W-1:0] wdata,
    output logic      [maa_pkg::SAMPLE_W-1:0] rdata_reg
);

    logic [maa_pkg::SAMPLE_W-1:0] mem [DEPTH];

    // Read-before-write: the evicted sample comes out as the new one goes in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            mem[addr] <= wdata;
        end
    end

endmodule : maa_sample_ring

`default_nettype wire

// ===== design/maa_flag_ring.sv =====
// ============================================================================
// maa_flag_ring
// Anomaly flag ring memory: one write port, two registered read ports,
// with write-to-read forwarding when a read hits the slot being written.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module maa_flag_ring #(
    parameter int DEPTH  = 100,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic              wr_flag,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic                   rd_flag_a_reg,
    output logic                   rd_flag_b_reg
);

    logic mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_flag;
        end
    end

    // Read ports; a same-edge write to the read slot is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_flag_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_flag : mem[rd_addr_a];
            rd_flag_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_flag : mem[rd_addr_b];
        end
    end

endmodule : maa_flag_ring

`default_nettype wire

// ===== design/moving_average_anomaly_alarm.sv =====
// ============================================================================
// moving_average_anomaly_alarm
// Throughput: one word per cycle while results are accepted, set by the
// single write port of each ring and the running-sum and flag-count
// registers, each updated once per word. Reset: control state clears at
// once; threshold resets to 75; the rings get no clearing pass, and their
// contents are used only after they have been written.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module moving_average_anomaly_alarm #(
    parameter int WINDOW_DEPTH    = maa_pkg::WINDOW_DEPTH_DEF,
    parameter int SUBWINDOW_DEPTH = maa_pkg::SUBWINDOW_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [maa_pkg::THRESH_W-1:0] cfg_wr_data,
    maa_sample_if.sink                        samples,
    maa_result_if.source                      results
);

    localparam int ADDR_W   = $clog2(WINDOW_DEPTH);
    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = maa_pkg::SAMPLE_W + ADDR_W;
    localparam int SPAN_MAX = (SUBWINDOW_DEPTH < WINDOW_DEPTH) ? SUBWINDOW_DEPTH
                                                               : WINDOW_DEPTH;
    localparam int CNT_W    = $clog2(SPAN_MAX + 1);
    localparam int T_W      = maa_pkg::THRESH_W;
    localparam int TS_W     = T_W + $clog2(SUBWINDOW_DEPTH + 1);
    localparam int CMP_W    = (CNT_W + T_W > TS_W) ? CNT_W + T_W : TS_W;
    localparam int FAC_W    = T_W + 1;
    localparam int PROD_W   = maa_pkg::SAMPLE_W + FAC_W;
    localparam int LIMIT_W  = maa_pkg::SAMPLE_W + 1;
    localparam bit ENTER_FROM_RING = (SUBWINDOW_DEPTH < WINDOW_DEPTH);
    localparam int ENTER_OFS       = ENTER_FROM_RING ? SUBWINDOW_DEPTH : 0;

    typedef struct packed {
        logic [maa_pkg::SAMPLE_W-1:0] sample;
        logic [ADDR_W-1:0]            slot;
        logic [ADDR_W-1:0]            ent_slot;  // slot that joins the sub-window
        logic                         full;      // oldest sample leaves the ring
        logic                         ent_mem;   // joining flag comes from the ring
        logic                         ent_new;   // joining flag is this word's own
        logic                         cal;
        logic [T_W-1:0]               t;
        logic [TS_W-1:0]              ts;        // t * sub-window depth
    } item_t;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [T_W-1:0]     thr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [ADDR_W-1:0]  oldest_reg;
    logic [FILL_W-1:0]  cal_cnt_reg;
    logic               is_cal_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [6:1]         rdy;
    logic [6:1]         mv;
    logic [5:1]         vld_reg;
    item_t              st_reg [1:5];

    logic               full_c;
    logic [ADDR_W-1:0]  slot_c;
    logic [ADDR_W:0]    ent_sum;
    logic [T_W-1:0]     t_sat;
    item_t              item_c;

    logic [maa_pkg::SAMPLE_W-1:0] old_sample;
    logic [maa_pkg::AVG_W-1:0]    avg3;
    logic [maa_pkg::AVG_W-1:0]    avg4_reg;
    logic [maa_pkg::AVG_W-1:0]    avg5_reg;
    logic [FAC_W-1:0]             fac_hi;
    logic [FAC_W-1:0]             fac_lo;
    logic [PROD_W-1:0]            hi_prod_reg;
    logic [PROD_W-1:0]            lo_prod_reg;
    logic [LIMIT_W-1:0]           hi5;
    logic [LIMIT_W-1:0]           lo5;
    logic                         leave_rd;
    logic                         enter_rd;
    logic                         flag5;
    logic                         leave5;
    logic                         enter5;
    logic                         alarm_c;

    logic                               out_vld_reg;
    logic                               out_alarm_reg;
    logic                               out_flag_reg;
    logic [maa_pkg::AVG_W-1:0]          out_avg_reg;
    logic [maa_pkg::COUNT_OUT_W-1:0]    out_count_reg;

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage moves when the next one has room
    // ------------------------------------------------------------------
    always_comb
    begin
        rdy[6] = !out_vld_reg || results.ready;
        for (int k = 5; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k + 1];
        end
        mv[1] = samples.valid && rdy[1];
        for (int k = 2; k <= 6; k++)
        begin
            mv[k] = vld_reg[k - 1] && rdy[k];
        end
    end

    assign samples.ready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            for (int k = 1; k <= 5; k++)
            begin
                if (mv[k])
                begin
                    vld_reg[k] <= 1'b1;
                end
                else if (mv[k + 1])
                begin
                    vld_reg[k] <= 1'b0;
                end
            end
            if (mv[6])
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Threshold register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= maa_pkg::THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Accept: slot selection, sub-window bookkeeping, ring pointers
    // ------------------------------------------------------------------
    assign full_c  = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign slot_c  = full_c ? oldest_reg : fill_reg[ADDR_W-1:0];
    assign ent_sum = {1'b0, slot_c} + (ADDR_W + 1)'(ENTER_OFS);
    assign t_sat   = (thr_reg > T_W'(maa_pkg::PERCENT_FULL)) ? T_W'(maa_pkg::PERCENT_FULL)
                                                             : thr_reg;

    always_comb
    begin
        item_c.sample   = samples.sample;
        item_c.slot     = slot_c;
        item_c.ent_slot = (ent_sum >= (ADDR_W + 1)'(WINDOW_DEPTH))
                        ? ADDR_W'(ent_sum - (ADDR_W + 1)'(WINDOW_DEPTH))
                        : ent_sum[ADDR_W-1:0];
        item_c.full     = full_c;
        item_c.ent_mem  = full_c && ENTER_FROM_RING;
        item_c.ent_new  = full_c ? !ENTER_FROM_RING : (int'(fill_reg) < SUBWINDOW_DEPTH);
        item_c.cal      = is_cal_reg;
        item_c.t        = t_sat;
        item_c.ts       = TS_W'(t_sat) * TS_W'(SUBWINDOW_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            oldest_reg  <= '0;
            cal_cnt_reg <= '0;
            is_cal_reg  <= 1'b0;
        end
        else if (mv[1])
        begin
            if (full_c)
            begin
                oldest_reg <= (oldest_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                         : oldest_reg + 1'b1;
            end
            else
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            // calibration runs for WINDOW_DEPTH + 1 words
            if (!is_cal_reg && (cal_cnt_reg != FILL_W'(WINDOW_DEPTH)))
            begin
                cal_cnt_reg <= cal_cnt_reg + 1'b1;
            end
            else
            begin
                is_cal_reg <= 1'b1;
            end
        end
    end

    // Stage payload shift
    always_ff @(posedge clk)
    begin
        if (mv[1])
        begin
            st_reg[1] <= item_c;
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (mv[k])
            begin
                st_reg[k] <= st_reg[k - 1];
            end
        end
    end

    // Sample ring: write new sample, fetch the one it replaces
    maa_sample_ring #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_sample_ring (
        .clk       (clk),
        .en        (mv[1]),
        .addr      (slot_c),
        .wdata     (samples.sample),
        .rdata_reg (old_sample)
    );

    // ------------------------------------------------------------------
    // Stage 1 -> 2: running window sum
    // ------------------------------------------------------------------
    assign sum_next = sum_reg + SUM_W'(st_reg[1].sample)
                    - (st_reg[1].full ? SUM_W'(old_sample) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (mv[2])
        begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: average = sum / WINDOW_DEPTH
    // ------------------------------------------------------------------
    maa_const_div #(
        .IN_W    (SUM_W),
        .DIVISOR (WINDOW_DEPTH),
        .OUT_W   (maa_pkg::AVG_W)
    ) u_avg_div (
        .clk          (clk),
        .en           (mv[3]),
        .dividend     (sum_reg),
        .quotient_reg (avg3)
    );

    // ------------------------------------------------------------------
    // Stage 3 -> 4: band products avg * (100 +/- t)
    // ------------------------------------------------------------------
    assign fac_hi = FAC_W'(maa_pkg::PERCENT_FULL) + FAC_W'(st_reg[3].t);
    assign fac_lo = FAC_W'(maa_pkg::PERCENT_FULL) - FAC_W'(st_reg[3].t);

    always_ff @(posedge clk)
    begin
        if (mv[4])
        begin
            hi_prod_reg <= PROD_W'(avg3) * PROD_W'(fac_hi);
            lo_prod_reg <= PROD_W'(avg3) * PROD_W'(fac_lo);
            avg4_reg    <= avg3;
        end
        if (mv[5])
        begin
            avg5_reg <= avg4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4 -> 5: band limits, flag ring reads
    // ------------------------------------------------------------------
    maa_const_div #(
        .IN_W    (PROD_W),
        .DIVISOR (maa_pkg::PERCENT_FULL),
        .OUT_W   (LIMIT_W)
    ) u_hi_div (
        .clk          (clk),
        .en           (mv[5]),
        .dividend     (hi_prod_reg),
        .quotient_reg (hi5)
    );

    maa_const_div #(
        .IN_W    (PROD_W),
        .DIVISOR (maa_pkg::PERCENT_FULL),
        .OUT_W   (LIMIT_W)
    ) u_lo_div (
        .clk          (clk),
        .en           (mv[5]),
        .dividend     (lo_prod_reg),
        .quotient_reg (lo5)
    );

    maa_flag_ring #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_flag_ring (
        .clk           (clk),
        .wr_en         (mv[6]),
        .wr_addr       (st_reg[5].slot),
        .wr_flag       (flag5),
        .rd_en         (mv[5]),
        .rd_addr_a     (st_reg[4].slot),
        .rd_addr_b     (st_reg[4].ent_slot),
        .rd_flag_a_reg (leave_rd),
        .rd_flag_b_reg (enter_rd)
    );

    // ------------------------------------------------------------------
    // Stage 5: flag, sub-window count, alarm
    // ------------------------------------------------------------------
    assign flag5  = st_reg[5].cal
                 && (({1'b0, st_reg[5].sample} >= hi5) || ({1'b0, st_reg[5].sample} <= lo5));
    assign leave5 = st_reg[5].full && leave_rd;
    assign enter5 = st_reg[5].ent_mem ? enter_rd : (st_reg[5].ent_new && flag5);

    assign count_next = count_reg - CNT_W'(leave5) + CNT_W'(enter5);
    // floor(count*100/S) >= t  <=>  count*100 >= t*S
    assign alarm_c    = (CMP_W'(count_next) * CMP_W'(maa_pkg::PERCENT_FULL))
                     >= CMP_W'(st_reg[5].ts);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (mv[6])
        begin
            count_reg <= count_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (mv[6])
        begin
            out_alarm_reg <= alarm_c;
            out_flag_reg  <= flag5;
            out_avg_reg   <= avg5_reg;
            out_count_reg <= maa_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign results.valid            = out_vld_reg;
    assign results.alarm            = out_alarm_reg;
    assign results.sample_anomalous = out_flag_reg;
    assign results.window_average   = out_avg_reg;
    assign results.flagged_count    = out_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_oldest_zero_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != FILL_W'(WINDOW_DEPTH)) |-> (oldest_reg == '0))
        else $error("oldest pointer moved before ring filled");

    a_cal_after_count: assert property (@(posedge clk) disable iff (!rst_n)
        is_cal_reg |-> (cal_cnt_reg == FILL_W'(WINDOW_DEPTH)))
        else $error("calibrated before calibration count completed");

    a_count_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fill_reg)
        else $error("flag count exceeds ring occupancy");

    a_count_within_span: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= SPAN_MAX)
        else $error("flag count exceeds sub-window span");

    a_flag_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.sample_anomalous) |-> is_cal_reg)
        else $error("anomaly flag raised during calibration");

endmodule : moving_average_anomaly_alarm

`default_nettype wire

// ===== verif/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for the moving-average anomaly alarm. A directed table
// covers reset behavior, sample extremes and threshold corners; a random
// stream of steady levels, spike bursts and noise follows, phase by phase,
// under several threshold settings. Every result word is compared, field by
// field, against its typed word or an in-bench predictor of the window, the
// flag ring and the alarm.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_W       = maa_pkg::SAMPLE_W;
    localparam int THRESH_W       = maa_pkg::THRESH_W;
    localparam int AVG_W          = maa_pkg::AVG_W;
    localparam int COUNT_OUT_W    = maa_pkg::COUNT_OUT_W;
    localparam int PERCENT_FULL   = maa_pkg::PERCENT_FULL;
    localparam int WIN            = maa_pkg::WINDOW_DEPTH_DEF;
    localparam int SUB            = maa_pkg::SUBWINDOW_DEPTH_DEF;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int IDLE_PCT       = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 7;
    localparam int PHASE_WORDS    = 200;
    localparam int QUIET_PHASE    = 3;
    localparam int RANDOM_PHASE   = 5;
    localparam int DIRECTED_ROWS  = 18;

    typedef struct packed {
        logic                   alarm;
        logic                   anomalous;
        logic [AVG_W-1:0]       avg;
        logic [COUNT_OUT_W-1:0] count;
    } detect_word_t;

    typedef enum logic {ROW_SAMPLE, ROW_THRESH} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [SAMPLE_W-1:0] value;
        logic              typed;
        detect_word_t      word;
    } stim_row_t;

    localparam detect_word_t NO_WORD = '0;

    // Directed rows; typed words are the obvious ones right after reset
    localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, 16'h0000, 1'b1, '{1'b0, 1'b0, 16'd0,    5'd0}},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'd655,  5'd0}},
        '{ROW_THRESH, 16'd0,    1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'd1310, 5'd0}},
        '{ROW_SAMPLE, 16'h0000, 1'b1, '{1'b1, 1'b0, 16'd1310, 5'd0}},
        '{ROW_THRESH, 16'd127,  1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'h5555, 1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'hAAAA, 1'b0, NO_WORD},
        '{ROW_THRESH, 16'd100,  1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'h0001, 1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'h8000, 1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'h7FFF, 1'b0, NO_WORD},
        '{ROW_THRESH, 16'd1,    1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'h1234, 1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'hFFFE, 1'b0, NO_WORD},
        '{ROW_THRESH, 16'd75,   1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, NO_WORD}
    };

    // Threshold per random phase; the random phase draws its own
    localparam logic [THRESH_W-1:0] PHASE_THRESH [PHASES] = '{
        7'd75, 7'd10, 7'd0, 7'd127, 7'd100, 7'd0, 7'd50
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [THRESH_W-1:0] cfg_wr_data;

    maa_sample_if sample_bus ();
    maa_result_if result_bus ();

    moving_average_anomaly_alarm DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (sample_bus.sink),
        .results     (result_bus.source)
    );

    always #HALF_PERIOD clk = ~clk;

    // Predictor state: window ring, flag ring, running sum, calibration
    logic [SAMPLE_W-1:0] win_samples [WIN];
    bit                  win_flags   [WIN];
    int unsigned         run_sum;
    int unsigned         fill;
    int unsigned         head;
    int unsigned         calib_cnt;
    bit                  calibrated;
    logic [THRESH_W-1:0] thr_reg;

    detect_word_t pending_words [$];

    // Stream generator state
    int unsigned base_level = 20000;
    int          burst_left = 0;
    int unsigned burst_kind = 0;

    bit gaps_on = 1'b1;
    int fail_count;
    int words_sent;
    int words_checked;
    int flagged_words;
    int alarm_words;
    int thresh_writes;

    // Advance the predictor by one sample and return the expected word
    function automatic detect_word_t predict_detector_word(logic [SAMPLE_W-1:0] s);
        int unsigned  t;
        int unsigned  slot;
        int unsigned  avg;
        int unsigned  upper;
        int unsigned  lower;
        int unsigned  hits;
        int unsigned  span;
        int unsigned  i;
        bit           flag;
        detect_word_t w;
        t    = (thr_reg > PERCENT_FULL) ? PERCENT_FULL : thr_reg;
        flag = 1'b0;
        if (fill >= WIN)
        begin
            slot    = head;
            run_sum = run_sum - win_samples[slot];
            head    = (slot + 1) % WIN;
        end
        else
        begin
            slot = (head + fill) % WIN;
            fill = fill + 1;
        end
        run_sum           = run_sum + s;
        win_samples[slot] = s;
        avg               = run_sum / WIN;
        if (calibrated)
        begin
            upper = (avg * (PERCENT_FULL + t)) / PERCENT_FULL;
            lower = (avg * (PERCENT_FULL - t)) / PERCENT_FULL;
            flag  = (s >= upper) || (s <= lower);
        end
        win_flags[slot] = flag;
        // oldest sub-window; missing entries count as clear
        span = (fill < SUB) ? fill : SUB;
        hits = 0;
        for (i = 0; i < span; i++)
            hits = hits + win_flags[(head + i) % WIN];
        w.alarm     = ((hits * PERCENT_FULL) / SUB) >= t;
        w.anomalous = flag;
        w.avg       = avg[AVG_W-1:0];
        w.count     = hits[COUNT_OUT_W-1:0];
        if (!calibrated && calib_cnt < WIN)
            calib_cnt = calib_cnt + 1;
        else
            calibrated = 1'b1;
        return w;
    endfunction

    // Steady level with small noise, spike bursts, level jumps, raw noise
    function automatic logic [SAMPLE_W-1:0] next_stream_sample();
        int          lvl;
        int unsigned roll;
        int unsigned spread;
        roll = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
            case (burst_kind)
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                default: return SAMPLE_W'($urandom);
            endcase
        end
        if (roll < 4)
        begin
            burst_left = $urandom_range(1, 30);
            burst_kind = $urandom_range(0, 2);
            return SAMPLE_W'($urandom);
        end
        if (roll < 7)
            return SAMPLE_W'($urandom);
        if (roll < 8)
            base_level = $urandom_range(200, 60000);
        spread = base_level / 50;
        lvl    = int'(base_level) - int'(spread) + int'($urandom_range(0, 2 * spread));
        if (lvl > 65535)
            lvl = 65535;
        if (lvl < 0)
            lvl = 0;
        return SAMPLE_W'(lvl);
    endfunction

    task automatic note_failure(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Send one sample word; the expectation is typed or predicted
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                               input detect_word_t typed_word);
        detect_word_t w;
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= s;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        w = predict_detector_word(s);
        pending_words.insert(pending_words.size(), typed ? typed_word : w);
        words_sent = words_sent + 1;
    endtask

    // Drain all outstanding words, then write the threshold
    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        thr_reg       = value;
        thresh_writes = thresh_writes + 1;
    endtask

    // Result sink: random back-pressure and word checking
    initial
    begin
        detect_word_t got;
        detect_word_t want;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                got = '{result_bus.alarm, result_bus.sample_anomalous,
                        result_bus.window_average, result_bus.flagged_count};
                if (pending_words.size() == 0)
                    note_failure("result word with nothing expected");
                else
                begin
                    want = pending_words[0];
                    pending_words.delete(0);
                    words_checked = words_checked + 1;
                    if (got.anomalous === 1'b1)
                        flagged_words = flagged_words + 1;
                    if (got.alarm === 1'b1)
                        alarm_words = alarm_words + 1;
                    if (got.alarm !== want.alarm || got.anomalous !== want.anomalous ||
                        got.avg !== want.avg || got.count !== want.count)
                        note_failure($sformatf(
                            "word %0d: alarm %b/%b anomalous %b/%b avg %0d/%0d count %0d/%0d",
                            words_checked, want.alarm, got.alarm, want.anomalous,
                            got.anomalous, want.avg, got.avg, want.count, got.count));
                end
            end
            result_bus.ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles with no word moving on either side
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_bus.valid && sample_bus.ready) ||
                (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        int          r;
        int          p;
        int          n;
        logic [THRESH_W-1:0] thr;
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        sample_bus.valid  <= 1'b0;
        sample_bus.sample <= '0;
        run_sum       = 0;
        fill          = 0;
        head          = 0;
        calib_cnt     = 0;
        calibrated    = 1'b0;
        thr_reg       = maa_pkg::THRESH_RESET;
        fail_count    = 0;
        words_sent    = 0;
        words_checked = 0;
        flagged_words = 0;
        alarm_words   = 0;
        thresh_writes = 0;
        for (r = 0; r < WIN; r++)
            win_flags[r] = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED_TABLE[r].kind == ROW_THRESH)
                write_threshold(DIRECTED_TABLE[r].value[THRESH_W-1:0]);
            else
                push_sample(DIRECTED_TABLE[r].value, DIRECTED_TABLE[r].typed,
                            DIRECTED_TABLE[r].word);
        end
        n = words_sent;

        // random phases, one threshold each
        for (p = 0; p < PHASES; p++)
        begin
            thr = (p == RANDOM_PHASE) ? THRESH_W'($urandom_range(1, 99)) : PHASE_THRESH[p];
            write_threshold(thr);
            gaps_on = (p != QUIET_PHASE);
            for (r = 0; r < PHASE_WORDS; r++)
                push_sample(next_stream_sample(), 1'b0, NO_WORD);
        end
        sample_bus.valid <= 1'b0;
        gaps_on = 1'b1;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run: %0d samples (%0d directed), %0d result words checked, %0d threshold writes",
                 words_sent, n, words_checked, thresh_writes);
        $display("Run: %0d words flagged anomalous, %0d with the alarm raised, %0d mismatches",
                 flagged_words, alarm_words, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb
